FILE: rtl/plf_pkg.sv
// Package for the PID line follower: widths, register reset values,
// register indexes and the control word of the shared multiply-accumulate unit.
// No dependencies.
`timescale 1ns / 1ps

package plf_pkg;

  // Default values of the top-level parameters.
  localparam int DEF_SAMPLE_BITS    = 12;
  localparam int DEF_GAIN_FRAC_BITS = 16;

  // Field and register widths.
  localparam int GAIN_W   = 24;
  localparam int OFFSET_W = 13;
  localparam int SPEED_W  = 10;
  localparam int RUN_W    = 20;
  localparam int DRIVE_W  = 10;
  localparam int ERR_W    = 14;
  localparam int SUM_W    = 24;
  localparam int DIFF_W   = ERR_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_SAMPLES   = 3'd5;

  // Register reset values.
  localparam logic [GAIN_W-1:0]          RST_GAIN_P      = 24'd150733;
  localparam logic [GAIN_W-1:0]          RST_GAIN_I      = 24'd115;
  localparam logic [GAIN_W-1:0]          RST_GAIN_D      = 24'd1310720;
  localparam logic signed [OFFSET_W-1:0] RST_SENSOR_OFF  = 13'sd0;
  localparam logic signed [SPEED_W-1:0]  RST_BASE_SPEED  = 10'sd200;
  localparam logic [RUN_W-1:0]           RST_RUN_SAMPLES = 20'd301;

  // Saturation limits.
  localparam int ERR_MAX   = 2**(ERR_W-1) - 1;
  localparam int ERR_MIN   = -(2**(ERR_W-1));
  localparam int SUM_MAX   = 2**(SUM_W-1) - 1;
  localparam int SUM_MIN   = -(2**(SUM_W-1));
  localparam int DRIVE_MAX = 500;

  // Shared multiplier: signed operands, product and accumulator widths.
  // The wide control value is multiplied in two halves split at HI_SHIFT.
  localparam int MUL_W    = 25;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = 60;
  localparam int HI_SHIFT = 24;

  // Output stream data width, whole bytes.
  localparam int OUT_DATA_W = ((2 * DRIVE_W + 7) / 8) * 8;

  // Control word of the multiply-accumulate unit.
  typedef struct packed {
    logic mul_en;  // load a new product
    logic hi;      // new product is weighted by 2**HI_SHIFT
    logic clear;   // start the accumulator from zero
    logic accum;   // add the held product to the accumulator
  } mac_ctrl_t;

endpackage

FILE: rtl/plf_mac.sv
// Shared multiply-accumulate unit of the PID line follower: one registered
// signed multiplier and a wide accumulator, steered by a control word.
// Depends on plf_pkg.
`timescale 1ns / 1ps

module plf_mac (
  input  logic                                clk,
  input  plf_pkg::mac_ctrl_t                  ctl,
  input  logic signed [plf_pkg::MUL_W-1:0]    op_a,
  input  logic signed [plf_pkg::MUL_W-1:0]    op_b,
  output logic signed [plf_pkg::ACC_W-1:0]    acc
);
  import plf_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_hi;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  acc_next;

  // Product register, with the weight flag that travels along with it.
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod    <= op_a * op_b;
      prod_hi <= ctl.hi;
    end
  end

  // Accumulate the held product, shifted up when it is the upper half.
  always_comb begin
    prod_ext = ACC_W'(prod);
    addend   = prod_hi ? (prod_ext <<< HI_SHIFT) : prod_ext;
    acc_next = (ctl.clear ? ACC_W'(0) : acc) + (ctl.accum ? addend : ACC_W'(0));
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

endmodule

FILE: rtl/pid_line_follower_unit.sv
// Top level of the PID line follower: configuration registers, controller
// state, sequencer and stream interfaces.
// Depends on plf_pkg and plf_mac.
`timescale 1ns / 1ps

// The block takes one transaction per control tick on the input stream: the
// left and right line-sensor samples in s_tdata and a restart flag in s_tuser.
// For each one it returns one transaction on the output stream with the left
// and right wheel drives in m_tdata and the run-over flag in m_tuser.
// A control tick runs from input acceptance through the sequencer to a valid
// result; a tick after the run is over goes from the error step straight to the
// output step. The sequencer walks the error, the integral update, three gain products
// and two speed products through one shared 25 x 25 multiplier, one step per cycle.
// s_tready is high only while the sequencer is idle, so a new tick is not accepted
// before the sequencer has handed the last one to the output register.
// A finished result sits in the output register; the next tick is accepted
// while it waits. If the receiver stalls, the following result is held in
// the sequencer until the output register is free.
// Configuration writes go through cfg_we/cfg_index/cfg_wdata and take effect
// at once; they are to be made by the user while the block is idle, a rule that
// the block leaves unenforced. Reset (rst, synchronous) loads the register defaults,
// clears error sum, previous error and tick count, and empties the output register.

module pid_line_follower_unit #(
  parameter int SAMPLE_BITS    = plf_pkg::DEF_SAMPLE_BITS,
  parameter int GAIN_FRAC_BITS = plf_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata: left_sample, right_sample (from bit 0 up), zero padded.
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
  // s_tuser: restart.
  input  logic [0:0]                          s_tuser,
  // Output stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata: left_drive, right_drive (from bit 0 up), zero padded.
  output logic [plf_pkg::OUT_DATA_W-1:0]      m_tdata,
  // m_tuser: done_res.
  output logic [0:0]                          m_tuser,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [plf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [plf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import plf_pkg::*;

  localparam int CTRL_SHIFT = GAIN_FRAC_BITS + SAMPLE_BITS;
  localparam int RAW_W      = ((SAMPLE_BITS + 1 > OFFSET_W) ? SAMPLE_BITS + 1 : OFFSET_W) + 1;
  localparam int QW         = ACC_W - CTRL_SHIFT;

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_SUM, S_MP, S_MI, S_MD, S_CL,
    S_SL, S_SH, S_SP, S_ADJ, S_SAT, S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [GAIN_W-1:0]          gain_p;
  logic [GAIN_W-1:0]          gain_i;
  logic [GAIN_W-1:0]          gain_d;
  logic signed [OFFSET_W-1:0] sensor_offset;
  logic signed [SPEED_W-1:0]  base_speed;
  logic [RUN_W-1:0]           run_samples;

  // Controller state.
  logic signed [SUM_W-1:0]    error_sum;
  logic signed [ERR_W-1:0]    previous_error;
  logic [RUN_W-1:0]           tick_count;

  // Working registers of one tick.
  logic [SAMPLE_BITS-1:0]     left_q;
  logic [SAMPLE_BITS-1:0]     right_q;
  logic                       restart_q;
  logic signed [ERR_W-1:0]    err;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [MUL_W-1:0]    ctrl_hi;
  logic signed [ACC_W-1:0]    q_left;
  logic signed [ACC_W-1:0]    q_right;
  logic signed [DRIVE_W-1:0]  res_left;
  logic signed [DRIVE_W-1:0]  res_right;
  logic                       res_done;

  // Shared unit interface.
  mac_ctrl_t                  mac_ctl;
  logic signed [MUL_W-1:0]    op_a;
  logic signed [MUL_W-1:0]    op_b;
  logic signed [ACC_W-1:0]    acc;

  // Combinational helpers.
  logic signed [RAW_W-1:0]    raw_err;
  logic signed [ERR_W-1:0]    err_sat;
  logic signed [SUM_W:0]      sum_wide;
  logic signed [SUM_W-1:0]    sum_sat;
  logic [RUN_W-1:0]           tick_eff;
  logic signed [ACC_W-1:0]    speed_scaled;
  logic signed [DRIVE_W-1:0]  left_sat;
  logic signed [DRIVE_W-1:0]  right_sat;

  // Divide by 2**CTRL_SHIFT rounding toward zero, then saturate the drive.
  function automatic logic signed [DRIVE_W-1:0] drive_of(input logic signed [ACC_W-1:0] q);
    logic                 rnd;
    logic signed [QW-1:0] t;
    logic signed [QW-1:0] r;
    begin
      rnd = q[ACC_W-1] & (|q[CTRL_SHIFT-1:0]);
      t   = $signed(q[ACC_W-1:CTRL_SHIFT]) + $signed(QW'({1'b0, rnd}));
      if (t > QW'(DRIVE_MAX)) begin
        r = QW'(DRIVE_MAX);
      end else if (t < QW'(-DRIVE_MAX)) begin
        r = QW'(-DRIVE_MAX);
      end else begin
        r = t;
      end
      drive_of = DRIVE_W'(r);
    end
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p        <= RST_GAIN_P;
      gain_i        <= RST_GAIN_I;
      gain_d        <= RST_GAIN_D;
      sensor_offset <= RST_SENSOR_OFF;
      base_speed    <= RST_BASE_SPEED;
      run_samples   <= RST_RUN_SAMPLES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAIN_P:        gain_p        <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_I:        gain_i        <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_D:        gain_d        <= cfg_wdata[GAIN_W-1:0];
        CFG_SENSOR_OFFSET: sensor_offset <= $signed(cfg_wdata[OFFSET_W-1:0]);
        CFG_BASE_SPEED:    base_speed    <= $signed(cfg_wdata[SPEED_W-1:0]);
        CFG_RUN_SAMPLES:   run_samples   <= cfg_wdata[RUN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Error: left minus right minus offset, saturated to the error range.
  always_comb begin
    raw_err = RAW_W'($signed({1'b0, left_q})) - RAW_W'($signed({1'b0, right_q}))
            - RAW_W'(sensor_offset);
    if (raw_err > RAW_W'(ERR_MAX)) begin
      err_sat = ERR_W'(ERR_MAX);
    end else if (raw_err < RAW_W'(ERR_MIN)) begin
      err_sat = ERR_W'(ERR_MIN);
    end else begin
      err_sat = ERR_W'(raw_err);
    end
  end

  // Saturating integral update.
  always_comb begin
    sum_wide = (SUM_W+1)'(error_sum) + (SUM_W+1)'(err);
    if (sum_wide > (SUM_W+1)'(SUM_MAX)) begin
      sum_sat = SUM_W'(SUM_MAX);
    end else if (sum_wide < (SUM_W+1)'(SUM_MIN)) begin
      sum_sat = SUM_W'(SUM_MIN);
    end else begin
      sum_sat = SUM_W'(sum_wide);
    end
  end

  assign tick_eff     = restart_q ? RUN_W'(0) : tick_count;
  assign speed_scaled = ACC_W'(base_speed) <<< CTRL_SHIFT;
  assign left_sat     = drive_of(q_left);
  assign right_sat    = drive_of(q_right);

  // Operand selection and control word of the shared unit per step.
  always_comb begin
    mac_ctl = '0;
    op_a    = '0;
    op_b    = '0;
    unique case (state)
      S_MP: begin
        mac_ctl = '{mul_en: 1'b1, hi: 1'b0, clear: 1'b1, accum: 1'b0};
        op_a    = $signed({1'b0, gain_p});
        op_b    = MUL_W'(err);
      end
      S_MI: begin
        mac_ctl = '{mul_en: 1'b1, hi: 1'b0, clear: 1'b0, accum: 1'b1};
        op_a    = $signed({1'b0, gain_i});
        op_b    = MUL_W'(error_sum);
      end
      S_MD: begin
        mac_ctl = '{mul_en: 1'b1, hi: 1'b0, clear: 1'b0, accum: 1'b1};
        op_a    = $signed({1'b0, gain_d});
        op_b    = MUL_W'(diff);
      end
      S_CL: begin
        mac_ctl = '{mul_en: 1'b0, hi: 1'b0, clear: 1'b0, accum: 1'b1};
      end
      S_SL: begin
        mac_ctl = '{mul_en: 1'b1, hi: 1'b0, clear: 1'b1, accum: 1'b0};
        op_a    = MUL_W'(base_speed);
        op_b    = $signed({1'b0, acc[HI_SHIFT-1:0]});
      end
      S_SH: begin
        mac_ctl = '{mul_en: 1'b1, hi: 1'b1, clear: 1'b0, accum: 1'b1};
        op_a    = MUL_W'(base_speed);
        op_b    = ctrl_hi;
      end
      S_SP: begin
        mac_ctl = '{mul_en: 1'b0, hi: 1'b0, clear: 1'b0, accum: 1'b1};
      end
      default: begin
      end
    endcase
  end

  plf_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  // Sequencer, controller state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_tvalid       <= 1'b0;
      error_sum      <= '0;
      previous_error <= '0;
      tick_count     <= '0;
    end else begin
      // An accepted result frees the output register unless a new one replaces it.
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            left_q    <= s_tdata[SAMPLE_BITS-1:0];
            right_q   <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            restart_q <= s_tuser[0];
            state     <= S_ERR;
          end
        end
        // Restart clears the state; a finished run answers at once.
        S_ERR: begin
          if (restart_q) begin
            error_sum      <= '0;
            previous_error <= '0;
            tick_count     <= '0;
          end
          err <= err_sat;
          if (tick_eff >= run_samples) begin
            res_left  <= '0;
            res_right <= '0;
            res_done  <= 1'b1;
            state     <= S_OUT;
          end else begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          error_sum      <= sum_sat;
          diff           <= DIFF_W'(err) - DIFF_W'(previous_error);
          previous_error <= err;
          tick_count     <= tick_count + RUN_W'(1);
          state          <= S_MP;
        end
        S_MP: state <= S_MI;
        S_MI: state <= S_MD;
        S_MD: state <= S_CL;
        S_CL: state <= S_SL;
        // The control value is in the accumulator; keep its upper half.
        S_SL: begin
          ctrl_hi <= acc[HI_SHIFT+MUL_W-1:HI_SHIFT];
          state   <= S_SH;
        end
        S_SH: state <= S_SP;
        // The accumulator holds speed times control.
        S_ADJ: begin
          q_left  <= speed_scaled - acc;
          q_right <= speed_scaled + acc;
          state   <= S_SAT;
        end
        S_SP: state <= S_ADJ;
        S_SAT: begin
          res_left  <= left_sat;
          res_right <= right_sat;
          res_done  <= 1'b0;
          state     <= S_OUT;
        end
        // Hand the result over once the output register is free.
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_DATA_W'({res_right, res_left});
            m_tuser  <= res_done;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);

  // A result that ends the run carries zero drive on both wheels.
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("run-over result with nonzero drive");

  // Both drives stay inside the saturation range.
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |->
      ($signed(m_tdata[DRIVE_W-1:0]) <= DRIVE_W'(DRIVE_MAX)) &&
      ($signed(m_tdata[DRIVE_W-1:0]) >= DRIVE_W'(-DRIVE_MAX)) &&
      ($signed(m_tdata[2*DRIVE_W-1:DRIVE_W]) <= DRIVE_W'(DRIVE_MAX)) &&
      ($signed(m_tdata[2*DRIVE_W-1:DRIVE_W]) >= DRIVE_W'(-DRIVE_MAX)))
    else $error("drive outside saturation range");

  // An accepted tick keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a tick is in progress");

endmodule
